FILE: hdl/chst_pkg.sv
package chst_pkg;

   // Field widths of the request and response items
   localparam int OP_W        = 2;
   localparam int SLOT_W      = 6;
   localparam int PAYLOAD_W   = 32;
   localparam int STATUS_W    = 2;
   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 40;
   localparam int REQ_PAD_W   = REQ_DATA_W - SLOT_W - PAYLOAD_W;
   localparam int RSP_PAD_W   = RSP_DATA_W - SLOT_W - PAYLOAD_W - 1;

   typedef enum logic [OP_W-1:0] {
      OP_ALLOC   = 2'd0,
      OP_RELEASE = 2'd1,
      OP_DELETE  = 2'd2,
      OP_CHECK   = 2'd3
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_FULL      = 2'd1,
      ST_NOT_ALLOC = 2'd2,
      ST_UNDERFLOW = 2'd3
   } status_type;

   // Command to the free-slot stack; at most one of the two is set
   typedef struct packed {
      logic push;
      logic pop;
   } stack_cmd_type;

endpackage

FILE: hdl/chst_payload_ram.sv
module chst_payload_ram
   import chst_pkg::*;
#(
   parameter int SLOTS        = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(SLOTS)-1:0] wr_addr,
   input  logic [PAYLOAD_BITS-1:0]  wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(SLOTS)-1:0] rd_addr,
   output logic [PAYLOAD_BITS-1:0]  rd_data
);

   logic [PAYLOAD_BITS-1:0] mem [SLOTS];
   logic [PAYLOAD_BITS-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Write-first: a read that meets a write to the same entry sees the new data
   always_ff @(posedge clock) begin
      if (rd_en) begin
         if (wr_en && (wr_addr == rd_addr)) begin
            rd_data_ff <= wr_data;
         end else begin
            rd_data_ff <= mem[rd_addr];
         end
      end
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: hdl/chst_free_stack.sv
module chst_free_stack
   import chst_pkg::*;
#(
   parameter int SLOTS = 64
) (
   input  logic                       clock,
   input  logic                       reset,
   input  stack_cmd_type              cmd,
   input  logic [$clog2(SLOTS)-1:0]   push_slot,
   output logic [$clog2(SLOTS)-1:0]   top,
   output logic [$clog2(SLOTS+1)-1:0] depth
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   // Top entry and the one under it live in flops; deeper entries in memory.
   // mem[i] holds stack entry i for i up to depth-2.
   logic [IDX_W-1:0] mem [SLOTS];
   logic [CNT_W-1:0] depth_ff, depth_in;
   logic [IDX_W-1:0] top_ff, top_in;
   logic [IDX_W-1:0] below_ff;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W-1:0] wr_addr;

   assign rd_addr = IDX_W'(depth_ff - CNT_W'(3));
   assign wr_addr = IDX_W'(depth_ff - CNT_W'(1));

   always_comb begin
      depth_in = depth_ff;
      top_in   = top_ff;
      if (cmd.pop) begin
         depth_in = depth_ff - CNT_W'(1);
         top_in   = below_ff;
      end else if (cmd.push) begin
         depth_in = depth_ff + CNT_W'(1);
         top_in   = push_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         depth_ff <= '0;
      end else begin
         depth_ff <= depth_in;
      end
   end

   always_ff @(posedge clock) begin
      top_ff <= top_in;
   end

   // Memory port: spill the old top on push, refill the second entry on pop
   always_ff @(posedge clock) begin
      if (cmd.push && (depth_ff != '0)) begin
         mem[wr_addr] <= top_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.pop) begin
         below_ff <= mem[rd_addr];
      end else if (cmd.push) begin
         below_ff <= top_ff;
      end
   end

   assign top   = top_ff;
   assign depth = depth_ff;

endmodule

FILE: hdl/counted_handle_slot_table.sv
// Counted handle slot table.
// Request channel (req_*): operation in tuser; slot and payload in tdata.
//   allocate stores the payload in the most recently freed slot, or else in the
//   next never-used slot; release drops the single holder and frees the slot;
//   delete clears the payload and then releases; check releases only if the
//   payload was deleted. One response item (rsp_*) per request item.
// Throughput: one item per cycle unless rsp_tready stalls the response. The
//   request sits in an input register whose payload memory read was issued
//   at accept; the decision, the flag update, the free-stack push or pop and
//   the memory write happen as the item leaves the input register, and its
//   result lands in the response register. Back-to-back accesses to one slot
//   are covered by write-first forwarding in the payload memory.
// Reset: present marks, holder counts, free-stack depth and the bump index
//   clear; payload and free-stack memories are not cleared and need no sweep,
//   so requests are taken right after reset.
// Stall: with rsp_tready low the response holds, one more request is held in
//   the input register, and req_tready then drops until the response is taken.
module counted_handle_slot_table
   import chst_pkg::*;
#(
   parameter int SLOTS        = 64,
   parameter int PAYLOAD_BITS = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // slot[5:0], payload[37:6], zero pad
   input  logic [OP_W-1:0]       req_tuser,   // operation[1:0]
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // slot_out[5:0], payload_out[37:6],
                                              // live[38], zero pad
   output logic [STATUS_W-1:0]   rsp_tuser    // status[1:0]
);

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int CMP_W = (CNT_W > SLOT_W) ? CNT_W : SLOT_W;

   // Handshake
   logic accept;
   logic fire;

   // Input register
   logic                 in_valid_ff, in_valid_in;
   op_type               in_op_ff;
   logic [SLOT_W-1:0]    in_slot_ff;
   logic [PAYLOAD_W-1:0] in_payload_ff;

   // Slot flags and bump index
   logic [SLOTS-1:0] present_ff, present_in;
   logic [SLOTS-1:0] count_ff, count_in;
   logic [CNT_W-1:0] next_unused_ff, next_unused_in;

   // Response register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;
   logic [PAYLOAD_W-1:0] rsp_payload_ff, rsp_payload_in;
   logic                 rsp_live_ff, rsp_live_in;
   status_type           rsp_status_ff, rsp_status_in;

   // Datapath between the two
   logic [CMP_W-1:0]        slot_ext;
   logic [IDX_W-1:0]        slot_idx;
   logic                    not_alloc;
   logic                    cur_present;
   logic                    cur_count;
   logic [IDX_W-1:0]        target_idx;
   logic                    flag_we;
   logic                    present_new;
   logic                    count_new;
   logic                    ram_we;
   logic [PAYLOAD_BITS-1:0] ram_wdata;
   logic [PAYLOAD_BITS-1:0] ram_rdata;
   logic [IDX_W-1:0]        ram_raddr;
   stack_cmd_type           stack_req;
   stack_cmd_type           stack_cmd;
   logic [IDX_W-1:0]        stack_top;
   logic [CNT_W-1:0]        stack_depth;
   logic                    stack_has_room;

   assign fire       = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || fire;
   assign accept     = req_tvalid && req_tready;

   // Payload read for the incoming item is issued as it is accepted
   assign ram_raddr = IDX_W'(CMP_W'(req_tdata[SLOT_W-1:0]));

   chst_payload_ram #(
      .SLOTS        (SLOTS),
      .PAYLOAD_BITS (PAYLOAD_BITS)
   ) u_payload_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (target_idx),
      .wr_data (ram_wdata),
      .rd_en   (accept),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign stack_cmd.push = fire && stack_req.push;
   assign stack_cmd.pop  = fire && stack_req.pop;

   chst_free_stack #(
      .SLOTS (SLOTS)
   ) u_free_stack (
      .clock     (clock),
      .reset     (reset),
      .cmd       (stack_cmd),
      .push_slot (target_idx),
      .top       (stack_top),
      .depth     (stack_depth)
   );

   assign stack_has_room = (stack_depth != CNT_W'(SLOTS));

   assign slot_ext    = CMP_W'(in_slot_ff);
   assign slot_idx    = IDX_W'(slot_ext);
   assign not_alloc   = (slot_ext >= CMP_W'(next_unused_ff));
   assign cur_present = present_ff[slot_idx];
   assign cur_count   = count_ff[slot_idx];

   // Decide the operation on the item in the input register
   always_comb begin
      target_idx     = slot_idx;
      flag_we        = 1'b0;
      present_new    = cur_present;
      count_new      = cur_count;
      ram_we         = 1'b0;
      ram_wdata      = '0;
      stack_req      = '0;
      next_unused_in = next_unused_ff;
      rsp_slot_in    = in_slot_ff;
      rsp_payload_in = PAYLOAD_W'(ram_rdata);
      rsp_live_in    = cur_present;
      rsp_status_in  = ST_OK;

      if (in_op_ff == OP_ALLOC) begin
         rsp_payload_in = PAYLOAD_W'(PAYLOAD_BITS'(in_payload_ff));
         rsp_live_in    = 1'b1;
         priority if (stack_depth != '0) begin
            // reuse the most recently freed slot
            target_idx    = stack_top;
            stack_req.pop = 1'b1;
         end else if (next_unused_ff != CNT_W'(SLOTS)) begin
            target_idx     = IDX_W'(next_unused_ff);
            next_unused_in = next_unused_ff + CNT_W'(1);
         end else begin
            // table full: nothing changes
            rsp_status_in = ST_FULL;
         end
         rsp_slot_in = SLOT_W'(CMP_W'(target_idx));
         if (rsp_status_in == ST_FULL) begin
            rsp_slot_in    = '0;
            rsp_payload_in = '0;
            rsp_live_in    = 1'b0;
         end else begin
            flag_we     = 1'b1;
            present_new = 1'b1;
            count_new   = 1'b1;
            ram_we      = fire;
            ram_wdata   = PAYLOAD_BITS'(in_payload_ff);
         end
      end else if (not_alloc) begin
         rsp_payload_in = '0;
         rsp_live_in    = 1'b0;
         rsp_status_in  = ST_NOT_ALLOC;
      end else begin
         logic drop;
         drop = 1'b0;
         unique case (in_op_ff)
            OP_RELEASE: begin
               drop = 1'b1;
            end
            OP_DELETE: begin
               drop           = 1'b1;
               flag_we        = 1'b1;
               present_new    = 1'b0;
               ram_we         = fire;
               ram_wdata      = '0;
               rsp_payload_in = '0;
               rsp_live_in    = 1'b0;
            end
            OP_CHECK: begin
               drop = !cur_present;
            end
            default: begin
               drop = 1'b0;
            end
         endcase
         if (drop) begin
            if (!cur_count) begin
               rsp_status_in = ST_UNDERFLOW;
            end else begin
               flag_we        = 1'b1;
               count_new      = 1'b0;
               stack_req.push = stack_has_room;
            end
         end
      end
   end

   always_comb begin
      present_in = present_ff;
      count_in   = count_ff;
      if (fire && flag_we) begin
         present_in[target_idx] = present_new;
         count_in[target_idx]   = count_new;
      end
   end

   always_comb begin
      priority if (accept) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_comb begin
      priority if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff    <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         present_ff     <= '0;
         count_ff       <= '0;
         next_unused_ff <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         present_ff   <= present_in;
         count_ff     <= count_in;
         if (fire) begin
            next_unused_ff <= next_unused_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff      <= op_type'(req_tuser);
         in_slot_ff    <= req_tdata[SLOT_W-1:0];
         in_payload_ff <= req_tdata[SLOT_W+PAYLOAD_W-1:SLOT_W];
      end
      if (fire) begin
         rsp_slot_ff    <= rsp_slot_in;
         rsp_payload_ff <= rsp_payload_in;
         rsp_live_ff    <= rsp_live_in;
         rsp_status_ff  <= rsp_status_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_live_ff, rsp_payload_ff, rsp_slot_ff};
   assign rsp_tuser  = rsp_status_ff;

endmodule

FILE: tb/slot_table_sb_pkg.sv
`timescale 1ns / 1ps

package slot_table_sb_pkg;
   import chst_pkg::*;

   localparam int SLOT_COUNT = 64;

   typedef struct {
      logic [SLOT_W-1:0]    slot;
      logic [PAYLOAD_W-1:0] payload;
      logic                 live;
      status_type           status;
   } slot_reply;

   class slot_table_scoreboard;
      logic [PAYLOAD_W-1:0] slot_value[SLOT_COUNT];
      bit                   slot_present[SLOT_COUNT];
      bit                   slot_held[SLOT_COUNT];
      int                   free_list[SLOT_COUNT];
      int                   free_count;
      int                   bump_index;
      slot_reply            awaited_replies[$];
      int                   errors;

      function new();
         for (int i = 0; i < SLOT_COUNT; i++) begin
            slot_value[i]   = '0;
            slot_present[i] = 1'b0;
            slot_held[i]    = 1'b0;
            free_list[i]    = 0;
         end
         free_count = 0;
         bump_index = 0;
         errors     = 0;
      endfunction

      function void queue_reply(slot_reply r);
         awaited_replies.insert(awaited_replies.size(), r);
      endfunction

      // one holder drops; freed slot goes on top of the free stack
      function status_type drop_holder(int s);
         if (!slot_held[s])
            return ST_UNDERFLOW;
         slot_held[s] = 1'b0;
         if (free_count < SLOT_COUNT) begin
            free_list[free_count] = s;
            free_count++;
         end
         return ST_OK;
      endfunction

      function void note_request(op_type op, logic [SLOT_W-1:0] slot,
                                 logic [PAYLOAD_W-1:0] payload);
         slot_reply  r;
         int         s;
         status_type st;
         s  = slot;
         st = ST_OK;
         if (op == OP_ALLOC) begin
            if (free_count > 0) begin
               free_count--;
               s = free_list[free_count];
            end else if (bump_index < SLOT_COUNT) begin
               s = bump_index;
               bump_index++;
            end else begin
               r = '{slot: '0, payload: '0, live: 1'b0, status: ST_FULL};
               queue_reply(r);
               return;
            end
            slot_value[s]   = payload;
            slot_present[s] = 1'b1;
            slot_held[s]    = 1'b1;
         end else if (s >= bump_index) begin
            r = '{slot: slot, payload: '0, live: 1'b0, status: ST_NOT_ALLOC};
            queue_reply(r);
            return;
         end else if (op == OP_RELEASE) begin
            st = drop_holder(s);
         end else if (op == OP_DELETE) begin
            slot_value[s]   = '0;
            slot_present[s] = 1'b0;
            st = drop_holder(s);
         end else if (!slot_present[s]) begin
            st = drop_holder(s);
         end
         r.slot    = SLOT_W'(s);
         r.payload = slot_value[s];
         r.live    = slot_present[s];
         r.status  = st;
         queue_reply(r);
      endfunction

      function void compare_field(string name, logic [63:0] want, logic [63:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_response(logic [SLOT_W-1:0] slot, logic [PAYLOAD_W-1:0] payload,
                                   logic live, logic [STATUS_W-1:0] status);
         slot_reply r;
         if (awaited_replies.size() == 0) begin
            $display("%0t: unexpected item, expected none, actual slot %0h status %0h",
                     $time, slot, status);
            errors++;
            return;
         end
         r = awaited_replies.pop_front();
         compare_field("slot_out", r.slot, slot);
         compare_field("payload_out", r.payload, payload);
         compare_field("live", r.live, live);
         compare_field("status", r.status, status);
      endfunction

      function int outstanding();
         return awaited_replies.size();
      endfunction
   endclass

endpackage

FILE: tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
   import chst_pkg::*;
   import slot_table_sb_pkg::*;

   localparam int IDLE_PCT    = 18;   // chance of a gap per cycle, in percent
   localparam int QUIET_FROM  = 260;  // window of items with no gaps on either side
   localparam int QUIET_TO    = 380;
   localparam int HOLD_AT     = 200;  // receiver hold-off starts after this many items
   localparam int HOLD_CYCLES = 60;
   localparam int STALL_LIMIT = 2000; // cycles with no item moving before giving up

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;   // slot[5:0], payload[37:6], zero pad
   logic [OP_W-1:0]       req_tuser;   // operation[1:0]
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;   // slot_out[5:0], payload_out[37:6], live[38], pad
   logic [STATUS_W-1:0]   rsp_tuser;   // status[1:0]

   slot_table_scoreboard table_sb;
   int                   items_sent;

   counted_handle_slot_table DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic bit quiet_window();
      return items_sent >= QUIET_FROM && items_sent < QUIET_TO;
   endfunction

   // Offer one item, with random gaps ahead of it; returns at the falling edge
   // after acceptance, where the prediction has already been noted.
   task automatic send_request(input op_type op, input logic [SLOT_W-1:0] slot,
                               input logic [PAYLOAD_W-1:0] payload);
      if (!quiet_window()) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(negedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {{REQ_PAD_W{1'b0}}, payload, slot};
      do @(posedge clock); while (!req_tready);
      table_sb.note_request(op, slot, payload);
      items_sent++;
      @(negedge clock);
   endtask

   // Slot for release, delete or check: mostly one already handed out,
   // sometimes anything, so that unallocated slots keep showing up.
   function automatic logic [SLOT_W-1:0] pick_slot();
      if (table_sb.bump_index > 0 && $urandom_range(99) < 85)
         return SLOT_W'($urandom_range(table_sb.bump_index - 1));
      return SLOT_W'($urandom_range(SLOT_COUNT - 1));
   endfunction

   task automatic random_request(input int alloc_pct);
      int pick;
      pick = $urandom_range(99);
      if ($urandom_range(99) < alloc_pct)
         send_request(OP_ALLOC, SLOT_W'($urandom), $urandom);
      else if (pick < 40)
         send_request(OP_RELEASE, pick_slot(), $urandom);
      else if (pick < 65)
         send_request(OP_DELETE, pick_slot(), $urandom);
      else
         send_request(OP_CHECK, pick_slot(), $urandom);
   endtask

   // Receiver: random back-pressure, one long hold-off once enough items are in
   // so the input side fills and stalls, and a quiet window with none at all.
   initial begin
      int  hold_left;
      bit  hold_done;
      hold_left  = 0;
      hold_done  = 1'b0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (!hold_done && items_sent >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (quiet_window()) begin
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Result monitor: every accepted response goes against the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         table_sb.check_response(rsp_tdata[SLOT_W-1:0],
                                 rsp_tdata[SLOT_W+PAYLOAD_W-1:SLOT_W],
                                 rsp_tdata[SLOT_W+PAYLOAD_W], rsp_tuser);
   end

   // Watchdog: too long with nothing moving on either side means a hang.
   initial begin
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("tb_top failed");
      $finish;
   end

   initial begin
      int alloc_pct;
      table_sb   = new();
      items_sent = 0;
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = OP_ALLOC;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: corner payloads, every operation, each special case but a full table.
      send_request(OP_RELEASE, 6'd0, 32'h0);          // nothing allocated yet
      send_request(OP_CHECK, 6'd63, 32'hFFFF_FFFF);   // top slot, never handed out
      send_request(OP_ALLOC, 6'd0, 32'h0000_0000);    // bump -> 0
      send_request(OP_ALLOC, 6'd63, 32'hFFFF_FFFF);   // bump -> 1
      send_request(OP_ALLOC, 6'd0, 32'hA5A5_5A5A);    // bump -> 2
      send_request(OP_CHECK, 6'd1, 32'h0);            // present, no change
      send_request(OP_RELEASE, 6'd1, 32'h0);          // freed, payload kept
      send_request(OP_CHECK, 6'd1, 32'h0);            // freed but still present
      send_request(OP_RELEASE, 6'd1, 32'h0);          // count already zero
      send_request(OP_ALLOC, 6'd0, 32'h1234_5678);    // reuses slot 1
      send_request(OP_DELETE, 6'd2, 32'h0);           // clear and free
      send_request(OP_DELETE, 6'd2, 32'h0);           // underflow, still clears
      send_request(OP_CHECK, 6'd2, 32'h0);            // deleted: release underflows
      send_request(OP_RELEASE, 6'd0, 32'h0);
      send_request(OP_DELETE, 6'd0, 32'h0);           // freed slot, delete underflows
      send_request(OP_CHECK, 6'd0, 32'h0);
      send_request(OP_ALLOC, 6'd0, 32'h8000_0001);    // last freed first: slot 0
      send_request(OP_ALLOC, 6'd0, 32'h7FFF_FFFE);    // then slot 2
      send_request(OP_ALLOC, 6'd0, 32'h5555_AAAA);    // stack empty, bump -> 3
      send_request(OP_CHECK, 6'd3, 32'h0);
      send_request(OP_CHECK, 6'd4, 32'h0);            // just past the bump index
      send_request(OP_DELETE, 6'd3, 32'h0);
      send_request(OP_ALLOC, 6'd0, 32'hDEAD_BEEF);

      // Random: segments alternate between filling the table (and hitting
      // full) and draining it through the free stack.
      for (int seg = 0; seg < 5; seg++) begin
         case (seg)
            0: alloc_pct = 90;
            1: alloc_pct = 30;
            2: alloc_pct = 60;
            3: alloc_pct = 85;
            default: alloc_pct = 35;
         endcase
         repeat (96) random_request(alloc_pct);
      end
      req_tvalid <= 1'b0;

      while (table_sb.outstanding() > 0)
         @(posedge clock);
      repeat (10) @(posedge clock);

      if (table_sb.errors == 0)
         $display("tb_top passed");
      else
         $display("tb_top failed");
      $finish;
   end

endmodule
